FILE: sv/maiir_pkg.sv
// Shared types, constants and the saturation helper of the multimode audio IIR filter.
`timescale 1ns / 1ps
`default_nettype none

package maiir_pkg;

	// Word formats: Q1.23 samples and Q2.22 coefficients.
	localparam int SAMPLE_WIDTH     = 24;
	localparam int COEF_FRAC_BITS   = 22;
	localparam int COEF_WIDTH       = 24;
	localparam int CFG_INDEX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH   = COEF_WIDTH;

	// One sample bit more for sums and differences of two samples.
	localparam int SAMPLE_EXT_WIDTH = SAMPLE_WIDTH + 1;
	// Room for a coefficient and for the value one in coefficient format.
	localparam int COEF_EXT_WIDTH   =
		((COEF_WIDTH > COEF_FRAC_BITS + 1) ? COEF_WIDTH : COEF_FRAC_BITS + 2) + 1;
	localparam int PROD_WIDTH       = SAMPLE_EXT_WIDTH + COEF_EXT_WIDTH;
	// Accumulator holds the sum of three products without overflow.
	localparam int ACC_WIDTH        = PROD_WIDTH + 2;

	// Allpass output gain 0.2, rounded to the coefficient format.
	localparam logic signed [COEF_FRAC_BITS-1:0] ALLPASS_GAIN =
		COEF_FRAC_BITS'(((64'sd1 <<< (COEF_FRAC_BITS + 1)) + 64'sd5) / 64'sd10);

	// Half an LSB of the result, added before the arithmetic shift.
	localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
		ACC_WIDTH'(64'sd1 <<< (COEF_FRAC_BITS - 1));

	// Sample range limits, at sample and accumulator width.
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_SAMPLE_MAX =
		ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACC_WIDTH-1:0] ACC_SAMPLE_MIN = -ACC_SAMPLE_MAX - 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FILTER_MODE     = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLE_COEF       = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BP_INPUT_SCALE  = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BP_FEEDBACK_ONE = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BP_FEEDBACK_TWO = 3'd4;

	// Filter selection.
	typedef enum logic [1:0] {
		MODE_ALLPASS  = 2'd0,
		MODE_LOWPASS  = 2'd1,
		MODE_HIGHPASS = 2'd2,
		MODE_BANDPASS = 2'd3
	} maiir_mode_t;

	// Register file contents handed to the datapath.
	typedef struct packed {
		maiir_mode_t                   filter_mode;
		logic signed [COEF_WIDTH-1:0]  pole_coef;
		logic signed [COEF_WIDTH-1:0]  bp_input_scale;
		logic signed [COEF_WIDTH-1:0]  bp_feedback_one;
		logic signed [COEF_WIDTH-1:0]  bp_feedback_two;
	} maiir_cfg_t;

	// Clamp an accumulator value to the signed sample range.
	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
		input logic signed [ACC_WIDTH-1:0] v);
		logic signed [SAMPLE_WIDTH-1:0] r;
		if (v > ACC_SAMPLE_MAX) begin
			r = SAMPLE_MAX;
		end else if (v < ACC_SAMPLE_MIN) begin
			r = SAMPLE_MIN;
		end else begin
			r = v[SAMPLE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/multimode_audio_iir_filter_core.sv
// Top level of the multimode audio IIR filter: handshake, registers and output stage.
//
// Usage:
//   Input words (sample_in, signed Q1.23) arrive on in_valid/in_ready; filtered
//   words (sample_out, same format, saturated) leave on out_valid/out_ready.
//   The five filter registers are written through cfg_write/cfg_index/cfg_data,
//   one per cycle, while no word is in flight; writes to unused indexes are dropped.
//   A word is captured in an input register, filtered combinationally against the
//   stored history, and placed in the output register. One word per cycle is
//   sustained while words keep coming and the receiver keeps out_ready high; that
//   rate is set by the history update loop through the multipliers.
//   When the receiver stalls, the output register holds its word, the input
//   register keeps the next one, and in_ready falls once both are full; nothing
//   is lost or repeated.
//   Reset clears the registers to zero (allpass mode), the sample history and the
//   ring position, and empties both stages. There is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multimode_audio_iir_filter_core
	import maiir_pkg::*;
(
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  sample_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
	input  wire logic                            cfg_write,
	input  wire logic [CFG_INDEX_WIDTH-1:0]      cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]       cfg_data
);

	maiir_cfg_t                      cfg_q;
	logic                            valid_s1;
	logic signed [SAMPLE_WIDTH-1:0]  sample_s1;
	logic                            out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  sample_out_q;
	logic                            advance;
	logic signed [SAMPLE_WIDTH-1:0]  result;

	// A captured word moves on whenever the output register is free or being emptied.
	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode     <= MODE_ALLPASS;
			cfg_q.pole_coef       <= '0;
			cfg_q.bp_input_scale  <= '0;
			cfg_q.bp_feedback_one <= '0;
			cfg_q.bp_feedback_two <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FILTER_MODE: begin
					cfg_q.filter_mode <= maiir_mode_t'(cfg_data[1:0]);
				end
				REG_POLE_COEF: begin
					cfg_q.pole_coef <= cfg_data[COEF_WIDTH-1:0];
				end
				REG_BP_INPUT_SCALE: begin
					cfg_q.bp_input_scale <= cfg_data[COEF_WIDTH-1:0];
				end
				REG_BP_FEEDBACK_ONE: begin
					cfg_q.bp_feedback_one <= cfg_data[COEF_WIDTH-1:0];
				end
				REG_BP_FEEDBACK_TWO: begin
					cfg_q.bp_feedback_two <= cfg_data[COEF_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample_in;
		end
	end

	// Filter arithmetic and history.
	maiir_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg_q),
		.sample (sample_s1),
		.result (result)
	);

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			sample_out_q <= result;
		end
	end

endmodule

`default_nettype wire

FILE: sv/maiir_datapath.sv
// Filter arithmetic and sample history of the multimode audio IIR filter.
`timescale 1ns / 1ps
`default_nettype none

module maiir_datapath
	import maiir_pkg::*;
(
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire maiir_cfg_t                      cfg,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  sample,
	output logic signed [SAMPLE_WIDTH-1:0]       result
);

	logic signed [SAMPLE_WIDTH-1:0]     hist0_q;
	logic signed [SAMPLE_WIDTH-1:0]     hist1_q;
	logic                               ring_pos_q;

	// Allpass section signals.
	logic signed [SAMPLE_WIDTH-1:0]     ap_a;
	logic signed [SAMPLE_EXT_WIDTH-1:0] ap_a_inc;
	logic signed [SAMPLE_EXT_WIDTH-1:0] ap_half;
	logic signed [ACC_WIDTH-1:0]        ap_diff;
	logic signed [SAMPLE_WIDTH-1:0]     ap_b;
	logic signed [SAMPLE_WIDTH+COEF_FRAC_BITS-1:0] ap_prod;
	logic signed [ACC_WIDTH-1:0]        ap_rnd;
	logic signed [SAMPLE_WIDTH-1:0]     ap_y;

	// One-pole and resonator signals.
	logic signed [SAMPLE_EXT_WIDTH-1:0] pole_diff;
	logic signed [SAMPLE_EXT_WIDTH-1:0] mul_a;
	logic signed [COEF_WIDTH-1:0]       mul_b;
	logic signed [SAMPLE_EXT_WIDTH+COEF_WIDTH-1:0] prod0;
	logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0]     prod1;
	logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0]     prod2;
	logic signed [ACC_WIDTH-1:0]        x_one;
	logic signed [ACC_WIDTH-1:0]        acc;
	logic signed [ACC_WIDTH-1:0]        iir_rnd;
	logic signed [SAMPLE_WIDTH-1:0]     iir_y;

	// Allpass: read the ring entry, feed back half of it, scale the new entry by 0.2 and add the entry read.
	assign ap_a     = ring_pos_q ? hist1_q : hist0_q;
	assign ap_a_inc = SAMPLE_EXT_WIDTH'(ap_a) + SAMPLE_EXT_WIDTH'(1);
	assign ap_half  = ap_a_inc >>> 1;
	assign ap_diff  = ACC_WIDTH'(sample) - ACC_WIDTH'(ap_half);
	assign ap_b     = sat_sample(ap_diff);
	assign ap_prod  = ap_b * ALLPASS_GAIN;
	assign ap_rnd   = (ACC_WIDTH'(ap_prod) + ROUND_HALF) >>> COEF_FRAC_BITS;
	assign ap_y     = sat_sample(ACC_WIDTH'(ap_a) + ap_rnd);

	// One-pole forms: x*(1+c) - h*c = x + (x-h)*c, and x*(1-c) - h*c = x - (x+h)*c.
	assign pole_diff = (cfg.filter_mode == MODE_HIGHPASS) ?
		(SAMPLE_EXT_WIDTH'(sample) + SAMPLE_EXT_WIDTH'(hist0_q)) :
		(SAMPLE_EXT_WIDTH'(sample) - SAMPLE_EXT_WIDTH'(hist0_q));

	// The first multiplier serves the one-pole filters and the resonator input.
	assign mul_a = (cfg.filter_mode == MODE_BANDPASS) ? SAMPLE_EXT_WIDTH'(sample) : pole_diff;
	assign mul_b = (cfg.filter_mode == MODE_BANDPASS) ? cfg.bp_input_scale : cfg.pole_coef;
	assign prod0 = mul_a * mul_b;
	assign prod1 = hist0_q * cfg.bp_feedback_one;
	assign prod2 = hist1_q * cfg.bp_feedback_two;
	assign x_one = ACC_WIDTH'(sample) <<< COEF_FRAC_BITS;

	// Sum of the products for the selected filter.
	always_comb begin
		case (cfg.filter_mode)
			MODE_LOWPASS: begin
				acc = x_one + ACC_WIDTH'(prod0);
			end
			MODE_HIGHPASS: begin
				acc = x_one - ACC_WIDTH'(prod0);
			end
			default: begin
				acc = ACC_WIDTH'(prod0) + ACC_WIDTH'(prod1) - ACC_WIDTH'(prod2);
			end
		endcase
	end

	assign iir_rnd = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
	assign iir_y   = sat_sample(iir_rnd);

	// Result selection.
	always_comb begin
		case (cfg.filter_mode)
			MODE_ALLPASS: begin
				result = ap_y;
			end
			default: begin
				result = iir_y;
			end
		endcase
	end

	// History update, once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q    <= '0;
			hist1_q    <= '0;
			ring_pos_q <= 1'b0;
		end else if (step) begin
			case (cfg.filter_mode)
				MODE_ALLPASS: begin
					if (ring_pos_q) begin
						hist1_q <= ap_b;
					end else begin
						hist0_q <= ap_b;
					end
					ring_pos_q <= ~ring_pos_q;
				end
				MODE_LOWPASS, MODE_HIGHPASS: begin
					hist0_q <= iir_y;
				end
				default: begin
					hist1_q <= hist0_q;
					hist0_q <= iir_y;
				end
			endcase
		end
	end

	// The ring position advances exactly on allpass words.
	a_ring_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		step && cfg.filter_mode == MODE_ALLPASS |=> ring_pos_q != $past(ring_pos_q))
		else $error("ring position did not advance on an allpass word");

	a_ring_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && cfg.filter_mode == MODE_ALLPASS) |=> $stable(ring_pos_q))
		else $error("ring position moved outside an allpass word");

	// One-pole filters store their output and leave the second entry alone.
	a_pole_hist: assert property (@(posedge clk) disable iff (!arst_n)
		step && (cfg.filter_mode == MODE_LOWPASS || cfg.filter_mode == MODE_HIGHPASS)
		|=> hist0_q == $past(result) && $stable(hist1_q))
		else $error("one-pole history update is wrong");

	// The resonator shifts its history by one.
	a_bp_shift: assert property (@(posedge clk) disable iff (!arst_n)
		step && cfg.filter_mode == MODE_BANDPASS
		|=> hist1_q == $past(hist0_q) && hist0_q == $past(result))
		else $error("resonator history did not shift");

endmodule

`default_nettype wire

FILE: verif/multimode_audio_iir_filter_core_test.sv
// Self-checking testbench of the multimode audio IIR filter core: directed table, random words and a predictor.
`timescale 1ns / 1ps

module multimode_audio_iir_filter_core_test;
	import maiir_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 5;
	localparam int TIMEOUT_NS = 3_000_000;
	localparam int WORDS_PER_PHASE = 250;
	localparam int RECONFIG_EVERY = 50;
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 64;
	localparam int PAUSE_AT = 200;
	localparam int TAIL_CYCLES = 8;
	localparam int REPORT_LINES = 20;

	// Idle mixes, in percent of cycles.
	localparam int IDLE_RARE = 14;
	localparam int IDLE_OFTEN = 87;
	localparam int IDLE_NONE = 0;

	// Indexes past the register list; writes there must have no effect.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO =
		CFG_INDEX_WIDTH'(int'(REG_BP_FEEDBACK_TWO) + 1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = '1;

	// Coefficient corner values, Q2.22.
	localparam logic [CFG_DATA_WIDTH-1:0] COEF_TOP = {1'b0, {(CFG_DATA_WIDTH-1){1'b1}}};
	localparam logic [CFG_DATA_WIDTH-1:0] COEF_BOTTOM = {1'b1, {(CFG_DATA_WIDTH-1){1'b0}}};
	localparam logic [CFG_DATA_WIDTH-1:0] COEF_ZERO = '0;

	// Fixed-point constants of the predictor.
	localparam longint COEF_ONE = longint'(1) << COEF_FRAC_BITS;
	localparam longint GAIN_POINT_TWO = ((longint'(1) << (COEF_FRAC_BITS + 1)) + 5) / 10;
	localparam longint WORD_HI = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
	localparam longint WORD_LO = -WORD_HI - 1;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_WORD,
		ROW_KNOWN
	} row_kind_t;

	// One line of the directed table.
	typedef struct packed {
		row_kind_t                       kind;
		logic [CFG_INDEX_WIDTH-1:0]      index;
		logic [CFG_DATA_WIDTH-1:0]       data;
		logic signed [SAMPLE_WIDTH-1:0]  word;
		logic signed [SAMPLE_WIDTH-1:0]  result;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic cfg_write;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	// Shadow copy of the filter registers and history.
	maiir_mode_t shadow_mode = MODE_ALLPASS;
	logic signed [COEF_WIDTH-1:0] shadow_pole = '0;
	logic signed [COEF_WIDTH-1:0] shadow_scale = '0;
	logic signed [COEF_WIDTH-1:0] shadow_fb_one = '0;
	logic signed [COEF_WIDTH-1:0] shadow_fb_two = '0;
	logic signed [SAMPLE_WIDTH-1:0] sample_hist [2] = '{'0, '0};
	logic ring_pos = 1'b0;

	logic signed [SAMPLE_WIDTH-1:0] expected_words [$];
	directed_row_t directed_rows [$];

	int src_idle_pct = IDLE_NONE;
	int sink_idle_pct = IDLE_NONE;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int results_checked = 0;
	int words_directed = 0;
	int words_random = 0;
	int writes_done = 0;

	multimode_audio_iir_filter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Print one mismatch line (the first few only) and count it.
	task automatic report_mismatch(input string what);
		if (mismatch_count < REPORT_LINES) begin
			$display("MISMATCH at %0t ns: %s", $time, what);
		end
		mismatch_count++;
	endtask

	// Clamp to the signed sample range.
	function automatic longint clip_to_sample(input longint v);
		longint r;
		r = v;
		if (v > WORD_HI) begin
			r = WORD_HI;
		end else if (v < WORD_LO) begin
			r = WORD_LO;
		end
		return r;
	endfunction

	// Shift right with rounding to nearest, ties toward plus infinity.
	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// Filter one word against the shadow state and advance that state.
	function automatic logic signed [SAMPLE_WIDTH-1:0] filter_predict(
		input logic signed [SAMPLE_WIDTH-1:0] x);
		longint xs, h0, h1, tap, fed, pole, y;
		xs = x;
		h0 = sample_hist[0];
		h1 = sample_hist[1];
		pole = shadow_pole;
		case (shadow_mode)
		MODE_ALLPASS: begin
			tap = sample_hist[ring_pos];
			fed = clip_to_sample(xs - round_shift(tap, 1));
			sample_hist[ring_pos] = fed[SAMPLE_WIDTH-1:0];
			y = clip_to_sample(tap + round_shift(fed * GAIN_POINT_TWO, COEF_FRAC_BITS));
			ring_pos = ~ring_pos;
		end
		MODE_LOWPASS: begin
			y = clip_to_sample(round_shift(xs * (COEF_ONE + pole) - h0 * pole,
				COEF_FRAC_BITS));
			sample_hist[0] = y[SAMPLE_WIDTH-1:0];
		end
		MODE_HIGHPASS: begin
			y = clip_to_sample(round_shift(xs * (COEF_ONE - pole) - h0 * pole,
				COEF_FRAC_BITS));
			sample_hist[0] = y[SAMPLE_WIDTH-1:0];
		end
		default: begin
			y = clip_to_sample(round_shift(xs * longint'(shadow_scale)
				+ h0 * longint'(shadow_fb_one) - h1 * longint'(shadow_fb_two),
				COEF_FRAC_BITS));
			sample_hist[1] = sample_hist[0];
			sample_hist[0] = y[SAMPLE_WIDTH-1:0];
		end
		endcase
		return y[SAMPLE_WIDTH-1:0];
	endfunction

	// Write one register while the block is idle and mirror it in the shadow copy.
	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [CFG_DATA_WIDTH-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
		REG_FILTER_MODE: begin
			shadow_mode = maiir_mode_t'(data[1:0]);
		end
		REG_POLE_COEF: begin
			shadow_pole = data;
		end
		REG_BP_INPUT_SCALE: begin
			shadow_scale = data;
		end
		REG_BP_FEEDBACK_ONE: begin
			shadow_fb_one = data;
		end
		REG_BP_FEEDBACK_TWO: begin
			shadow_fb_two = data;
		end
		default: begin
		end
		endcase
		writes_done++;
	endtask

	// Offer one word, wait for it to be taken, queue its expected result, then maybe idle.
	task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] x, input bit known,
		input logic signed [SAMPLE_WIDTH-1:0] typed);
		logic signed [SAMPLE_WIDTH-1:0] predicted;
		in_valid <= 1'b1;
		sample_in <= x;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predicted = filter_predict(x);
		expected_words.push_back(known ? typed : predicted);
		if (src_idle_pct != IDLE_NONE && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < src_idle_pct);
		end
	endtask

	// Stop offering words until every expected result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	// Corner values, anything at all, or a value from a useful range.
	function automatic logic [CFG_DATA_WIDTH-1:0] random_coef(input int tame_lo,
		input int tame_hi);
		logic [CFG_DATA_WIDTH-1:0] c;
		case ($urandom_range(7))
		0: begin
			c = COEF_TOP;
		end
		1: begin
			c = COEF_BOTTOM;
		end
		2: begin
			c = COEF_ZERO;
		end
		3, 4: begin
			c = CFG_DATA_WIDTH'($urandom);
		end
		default: begin
			c = CFG_DATA_WIDTH'(int'($urandom_range(tame_hi - tame_lo)) + tame_lo);
		end
		endcase
		return c;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
		logic signed [SAMPLE_WIDTH-1:0] v;
		case ($urandom_range(9))
		0: begin
			v = SAMPLE_MAX;
		end
		1: begin
			v = SAMPLE_MIN;
		end
		2, 3: begin
			v = SAMPLE_WIDTH'(int'($urandom_range(4095)) - 2048);
		end
		default: begin
			v = SAMPLE_WIDTH'($urandom);
		end
		endcase
		return v;
	endfunction

	// New random filter setting; junk in the upper mode bits and now and then a spare index.
	task automatic randomize_setting();
		logic [CFG_DATA_WIDTH-1:0] mode_word;
		mode_word = CFG_DATA_WIDTH'($urandom);
		mode_word[1:0] = 2'($urandom_range(3));
		write_reg(REG_FILTER_MODE, mode_word);
		write_reg(REG_POLE_COEF, random_coef(int'(-COEF_ONE), int'(COEF_ONE)));
		write_reg(REG_BP_INPUT_SCALE, random_coef(0, int'(COEF_ONE)));
		write_reg(REG_BP_FEEDBACK_ONE, random_coef(int'(-(COEF_ONE * 7) / 4),
			int'((COEF_ONE * 7) / 4)));
		write_reg(REG_BP_FEEDBACK_TWO, random_coef(int'((COEF_ONE * 3) / 4),
			int'(COEF_ONE - 1)));
		if ($urandom_range(3) == 0) begin
			write_reg(CFG_INDEX_WIDTH'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
				CFG_DATA_WIDTH'($urandom));
		end
	endtask

	task automatic add_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [CFG_DATA_WIDTH-1:0] data);
		directed_rows.push_back('{ROW_WRITE, idx, data, '0, '0});
	endtask

	task automatic add_word(input logic signed [SAMPLE_WIDTH-1:0] x);
		directed_rows.push_back('{ROW_WORD, '0, '0, x, '0});
	endtask

	task automatic add_known(input logic signed [SAMPLE_WIDTH-1:0] x,
		input logic signed [SAMPLE_WIDTH-1:0] y);
		directed_rows.push_back('{ROW_KNOWN, '0, '0, x, y});
	endtask

	// Receiver: random ready, or a long hold counted here when one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_requests != hold_served) begin
			out_ready <= 1'b0;
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Compare each delivered word with the oldest expectation.
	always @(posedge clk) begin : result_check
		logic signed [SAMPLE_WIDTH-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("word %0d delivered with nothing expected",
					sample_out));
			end else begin
				want = expected_words.pop_front();
				results_checked++;
				if (sample_out !== want) begin
					report_mismatch($sformatf("sample_out %0d, expected %0d",
						sample_out, want));
				end
			end
		end
	end

	initial begin : stimulus
		directed_row_t row;
		in_valid <= 1'b0;
		sample_in <= '0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (RESET_CYCLES) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// Allpass right after reset: empty history gives zero out for zero in.
		add_known('0, '0);
		add_word(SAMPLE_MAX);
		add_word(SAMPLE_MIN);
		add_word(SAMPLE_WIDTH'(-1));
		add_word(SAMPLE_WIDTH'(1));
		// Lowpass; only the low two bits of the mode word count. A zero pole passes words through.
		add_write(REG_FILTER_MODE, 24'hFFFFFD);
		add_write(REG_POLE_COEF, COEF_ZERO);
		add_known(SAMPLE_MAX, SAMPLE_MAX);
		add_known(SAMPLE_MIN, SAMPLE_MIN);
		add_known('0, '0);
		add_write(REG_POLE_COEF, COEF_TOP);
		add_word(SAMPLE_MAX);
		add_word(SAMPLE_MIN);
		add_word(SAMPLE_MIN);
		add_write(REG_POLE_COEF, COEF_BOTTOM);
		add_word(SAMPLE_MAX);
		add_word(SAMPLE_MIN);
		// Highpass at the most negative pole, then pass-through with a zero pole.
		add_write(REG_FILTER_MODE, CFG_DATA_WIDTH'(MODE_HIGHPASS));
		add_word(SAMPLE_MAX);
		add_word(SAMPLE_MIN);
		add_write(REG_POLE_COEF, COEF_ZERO);
		add_known(24'sh123456, 24'sh123456);
		// Resonator with gain near two and no feedback saturates at both ends.
		add_write(REG_FILTER_MODE, CFG_DATA_WIDTH'(MODE_BANDPASS));
		add_write(REG_BP_INPUT_SCALE, COEF_TOP);
		add_write(REG_BP_FEEDBACK_ONE, COEF_ZERO);
		add_write(REG_BP_FEEDBACK_TWO, COEF_ZERO);
		add_known(SAMPLE_MAX, SAMPLE_MAX);
		add_known(SAMPLE_MIN, SAMPLE_MIN);
		add_write(REG_BP_FEEDBACK_ONE, COEF_TOP);
		add_write(REG_BP_FEEDBACK_TWO, COEF_BOTTOM);
		add_word(SAMPLE_MAX);
		add_word(SAMPLE_WIDTH'(-1000));
		// Writes past the register list are dropped.
		for (int i = int'(REG_SPARE_LO); i <= int'(REG_SPARE_HI); i++) begin
			add_write(CFG_INDEX_WIDTH'(i), 24'hFFFFFF);
		end
		add_word(SAMPLE_WIDTH'(500));
		// Back to allpass: the history left by the resonator is kept.
		add_write(REG_FILTER_MODE, CFG_DATA_WIDTH'(MODE_ALLPASS));
		add_word(SAMPLE_MIN);
		add_word('0);

		src_idle_pct = IDLE_RARE;
		sink_idle_pct = IDLE_OFTEN;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.index, row.data);
			end else begin
				send_word(row.word, row.kind == ROW_KNOWN, row.result);
				words_directed++;
			end
		end

		// Random words in three idle mixes, with a fresh setting every few dozen words.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				src_idle_pct = IDLE_RARE;
				sink_idle_pct = IDLE_OFTEN;
			end
			1: begin
				src_idle_pct = IDLE_OFTEN;
				sink_idle_pct = IDLE_RARE;
			end
			default: begin
				src_idle_pct = IDLE_NONE;
				sink_idle_pct = IDLE_NONE;
			end
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (n % RECONFIG_EVERY == 0) begin
					settle();
					randomize_setting();
				end
				if (n == HOLD_AT) begin
					hold_requests++;
				end
				if (n == PAUSE_AT) begin
					settle();
				end
				send_word(random_sample(), 1'b0, '0);
				words_random++;
			end
		end

		settle();
		repeat (TAIL_CYCLES) begin
			@(posedge clk);
		end
		if (expected_words.size() != 0) begin
			report_mismatch($sformatf("%0d expected words never delivered",
				expected_words.size()));
		end
		$display("Run covered %0d directed and %0d random words, %0d register writes,",
			words_directed, words_random, writes_done);
		$display("all four filter modes, sender and receiver idling, long receiver holds; %0d %s",
			results_checked, "words checked.");
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d words still expected", expected_words.size());
		$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
sv/maiir_pkg.sv
sv/maiir_datapath.sv
sv/multimode_audio_iir_filter_core.sv
verif/multimode_audio_iir_filter_core_test.sv
